/* rtl/stationary_interval_segmenter_assert.svh */
// Assertion macros used by the stationary interval segmenter checker.
// Each macro builds one labeled concurrent assertion with a clock and an active-low reset.
`ifndef STATIONARY_INTERVAL_SEGMENTER_ASSERT_SVH
`define STATIONARY_INTERVAL_SEGMENTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SIS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SIS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/sis_pkg.sv */
// Package for the stationary interval segmenter: widths, limits and item types.
// Depends on nothing; every other RTL file but the assertion macros header imports it.
package sis_pkg;

	localparam int IDX_W = 17;
	localparam int ANGLE_W = 32;
	localparam logic [IDX_W-1:0] MAX_SAMPLES = IDX_W'(65536);
	localparam logic [IDX_W-1:0] FIRST_INDEX = IDX_W'(1);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef logic [IDX_W-1:0] index_t;
	typedef logic signed [ANGLE_W-1:0] angle_t;

	typedef struct packed {
		index_t begin_index;
		index_t end_index;
		angle_t interval_angle;
		logic   final_result;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

/* rtl/sis_sample_if.sv */
// Input channel of the stationary interval segmenter: one sample item per handshake.
// Depends on sis_pkg for the angle type.
interface sis_sample_if;
	import sis_pkg::*;

	logic   valid;
	logic   ready;
	logic   moving;
	angle_t angle;
	logic   last_sample;

	modport source (output valid, output moving, output angle, output last_sample,
		input ready);
	modport sink (input valid, input moving, input angle, input last_sample,
		output ready);

endinterface

/* rtl/sis_interval_if.sv */
// Output channel of the stationary interval segmenter: one interval item per handshake.
// Depends on sis_pkg for the index and angle types.
interface sis_interval_if;
	import sis_pkg::*;

	logic   valid;
	logic   ready;
	index_t begin_index;
	index_t end_index;
	angle_t interval_angle;
	logic   final_result;

	modport source (output valid, output begin_index, output end_index,
		output interval_angle, output final_result, input ready);
	modport sink (input valid, input begin_index, input end_index,
		input interval_angle, input final_result, output ready);

endinterface

/* rtl/sis_front.sv */
// Front part: accepts samples, cleans the held sample and tracks stationary runs.
// Produces zero to two interval items per sample; depends on sis_pkg and sis_sample_if.
module sis_front (
	input  logic           clk,
	input  logic           arst_n,
	sis_sample_if.sink     samples,
	input  logic           room,
	output sis_pkg::push_t push
);
	import sis_pkg::*;

	logic   pend_valid_q;
	logic   pend_moving_q;
	angle_t pend_angle_q;
	index_t idx_q;
	logic   inside_q;
	index_t run_begin_q;
	angle_t run_angle_q;

	logic    accept;
	logic    pm_clean;
	logic    close1, open1, inside1;
	index_t  rb1, end1, idx1;
	angle_t  ra1;
	logic    close2, open2, flush;
	index_t  rb2, end2, end3;
	angle_t  ra2;
	result_t res1, res2, res3;

	assign samples.ready = room;
	assign accept = samples.valid && samples.ready;

	always_comb begin
		pm_clean = pend_moving_q && !(!samples.moving && (pend_angle_q == samples.angle));
		close1 = pend_valid_q && inside_q && pm_clean;
		open1 = pend_valid_q && !inside_q && !pm_clean;
		inside1 = pend_valid_q ? !pm_clean : inside_q;
		rb1 = open1 ? idx_q : run_begin_q;
		ra1 = open1 ? pend_angle_q : run_angle_q;
		end1 = (idx_q > run_begin_q) ? idx_q - FIRST_INDEX : run_begin_q;
		idx1 = (pend_valid_q && (idx_q < MAX_SAMPLES)) ? idx_q + FIRST_INDEX : idx_q;

		close2 = samples.last_sample && inside1 && samples.moving;
		open2 = samples.last_sample && !inside1 && !samples.moving;
		flush = samples.last_sample && !samples.moving;
		rb2 = open2 ? idx1 : rb1;
		ra2 = open2 ? samples.angle : ra1;
		end2 = (idx1 > rb1) ? idx1 - FIRST_INDEX : rb1;
		end3 = (idx1 > rb2) ? idx1 : rb2;

		res1 = '{begin_index: run_begin_q, end_index: end1, interval_angle: run_angle_q,
			final_result: samples.last_sample && !flush};
		res2 = '{begin_index: rb1, end_index: end2, interval_angle: ra1,
			final_result: samples.last_sample};
		res3 = '{begin_index: rb2, end_index: end3, interval_angle: ra2,
			final_result: 1'b1};

		push.first = close1 ? res1 : (close2 ? res2 : res3);
		push.second = res3;
		push.count = accept ? (2'(close1) + 2'(close2) + 2'(flush)) : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_moving_q <= 1'b0;
			pend_angle_q <= '0;
			idx_q <= FIRST_INDEX;
			inside_q <= 1'b0;
			run_begin_q <= '0;
			run_angle_q <= '0;
		end else if (accept) begin
			if (samples.last_sample) begin
				pend_valid_q <= 1'b0;
				pend_moving_q <= 1'b0;
				pend_angle_q <= '0;
				idx_q <= FIRST_INDEX;
				inside_q <= 1'b0;
				run_begin_q <= '0;
				run_angle_q <= '0;
			end else begin
				pend_valid_q <= 1'b1;
				pend_moving_q <= samples.moving;
				pend_angle_q <= samples.angle;
				idx_q <= idx1;
				inside_q <= inside1;
				run_begin_q <= rb1;
				run_angle_q <= ra1;
			end
		end
	end

endmodule

/* rtl/sis_queue.sv */
// Back part: a short queue of interval items that drives the output channel.
// Takes up to two items a cycle from the front part while room is high; depends on sis_pkg and sis_interval_if.
module sis_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  sis_pkg::push_t push,
	output logic           room,
	sis_interval_if.source intervals
);
	import sis_pkg::*;

	result_t           mem [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	result_t           head;

	assign room = count_q <= QCNT_W'(QDEPTH - 2);
	assign pop = intervals.valid && intervals.ready;
	assign head = mem[rd_ptr_q];

	assign intervals.valid = count_q != '0;
	assign intervals.begin_index = head.begin_index;
	assign intervals.end_index = head.end_index;
	assign intervals.interval_angle = head.interval_angle;
	assign intervals.final_result = head.final_result;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem[wr_ptr_q + QPTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + QPTR_W'(pop);
			count_q <= count_q + QCNT_W'(push.count) - QCNT_W'(pop);
		end
	end

endmodule

/* rtl/stationary_interval_segmenter.sv */
// Top level of the stationary interval segmenter: front part, queue, channel interfaces.
// Depends on sis_pkg, sis_sample_if, sis_interval_if, sis_front and sis_queue.
//
//   Channel     Items      Fields
//   samples     in         moving, angle, last_sample
//   intervals   out        begin_index, end_index, interval_angle, final_result
//
// A sample is taken every cycle while the four-entry queue has room for two items.
// An interval item is written into the queue by the sample that closes or flushes it, then offered from the head.
// A final sample can give two items; the queue drains one item per cycle while intervals.ready is high.
// A stalled output fills the queue, then holds samples.ready low.
// Reset clears the run tracking and empties the queue.
module stationary_interval_segmenter (
	input  logic           clk,
	input  logic           arst_n,
	sis_sample_if.sink     samples,
	sis_interval_if.source intervals
);
	import sis_pkg::*;

	push_t push;
	logic  room;

	sis_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.room    (room),
		.push    (push)
	);

	sis_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.intervals (intervals)
	);

endmodule

/* rtl/sis_checker.sv */
// Port checker for the stationary interval segmenter, attached by a bind statement.
// Depends on sis_pkg and the assertion macros header.
`include "stationary_interval_segmenter_assert.svh"

module sis_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            res_valid,
	input logic            res_ready,
	input sis_pkg::index_t begin_index,
	input sis_pkg::index_t end_index,
	input sis_pkg::angle_t interval_angle,
	input logic            final_result
);
	import sis_pkg::*;

	`SIS_ASSERT_SAME(a_order, clk, arst_n, res_valid, begin_index <= end_index, "interval ends before it begins")
	`SIS_ASSERT_SAME(a_begin, clk, arst_n, res_valid, begin_index != '0, "interval begins at index zero")
	`SIS_ASSERT_SAME(a_limit, clk, arst_n, res_valid, end_index <= MAX_SAMPLES, "interval index beyond limit")
	`SIS_ASSERT_NEXT(a_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(begin_index) && $stable(end_index) && $stable(interval_angle) && $stable(final_result), "stalled item changed")

endmodule

bind stationary_interval_segmenter sis_checker u_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (intervals.valid),
	.res_ready      (intervals.ready),
	.begin_index    (intervals.begin_index),
	.end_index      (intervals.end_index),
	.interval_angle (intervals.interval_angle),
	.final_result   (intervals.final_result)
);
